// ----- hw/rtl/sliding_window_extremum_macros.svh -----
// ----------------------------------------------------------------------------
// sliding window extremum assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_EXTREMUM_MACROS_SVH
`define SLIDING_WINDOW_EXTREMUM_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SWE_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define SWE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SWE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SWE_ASSERT(lbl, clk, rst_n, expr, msg)
`define SWE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SWE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/swe_pkg.sv -----
// ----------------------------------------------------------------------------
// swe_pkg
// shared constants and cell control type of the sliding window extremum
// ----------------------------------------------------------------------------
package swe_pkg;

    localparam int WS_W      = 7;
    localparam int POS_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTREME_MODE = 1'd1;

    localparam logic [WS_W-1:0] WS_RESET = 7'd3;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    typedef struct packed {
        logic step;
        logic shift;
        logic clear;
        logic mode;
    } swe_ctrl_t;

endpackage

// ----- hw/rtl/swe_cell.sv -----
// ----------------------------------------------------------------------------
// swe_cell
// one deque entry: holds value and position, checks dominance against the
// incoming sample and shifts toward the front with its neighbors
// ----------------------------------------------------------------------------
module swe_cell #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  swe_pkg::swe_ctrl_t               ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0]   in_sample,
    input  logic [swe_pkg::POS_W-1:0]        in_pos,
    input  logic                             left_keep,
    input  logic                             right_keep,
    input  logic signed [SAMPLE_WIDTH-1:0]   right_value,
    input  logic [swe_pkg::POS_W-1:0]        right_pos,
    output logic                             keep,
    output logic                             valid,
    output logic signed [SAMPLE_WIDTH-1:0]   value,
    output logic [swe_pkg::POS_W-1:0]        pos
);
    import swe_pkg::*;

    logic                           valid_reg, valid_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg, value_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic                           dom;

    assign dom  = (ctrl.mode == MODE_MIN) ? (value_reg >= in_sample)
                                          : (value_reg <= in_sample);
    // entry survives if it or anything behind it is not dominated
    assign keep = valid_reg & (~dom | right_keep);

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.step) begin
            if (ctrl.shift) begin
                if (right_keep) begin
                    valid_next = 1'b1;
                    value_next = right_value;
                    pos_next   = right_pos;
                end else if (keep) begin
                    valid_next = 1'b1;
                    value_next = in_sample;
                    pos_next   = in_pos;
                end else begin
                    valid_next = 1'b0;
                end
            end else begin
                if (keep) begin
                    valid_next = 1'b1;
                end else if (left_keep) begin
                    valid_next = 1'b1;
                    value_next = in_sample;
                    pos_next   = in_pos;
                end else begin
                    valid_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign pos   = pos_reg;

endmodule

// ----- hw/rtl/sliding_window_extremum.sv -----
// ----------------------------------------------------------------------------
// sliding_window_extremum
// window maximum or minimum over a stream of signed samples, kept in a
// monotonic deque held by a row of cells, with a running min of maxima or
// max of minima
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: sample; s_tlast: last item
// m_        out  m_tvalid/m_tready  m_tdata: extreme, aggregate;
//                                   m_tuser: window_ready, aggregate_valid;
//                                   m_tlast: sequence end
// cfg_      in   cfg_we             cfg_idx, cfg_wdata
//
// one word per cycle while the output is not stalled, result registered on acceptance
// the rate is set by the cell row, which updates on each accepted word: every cell
// compares with the new sample and the keep chain runs back to front
// synchronous reset, no clearing pass; deque entries carry their own valid bits
// s_tready falls only while a result is held and m_tready is low
// ----------------------------------------------------------------------------
module sliding_window_extremum #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [swe_pkg::CFG_IDX_W-1:0]          cfg_idx,
    input  logic [swe_pkg::WS_W-1:0]               cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [SAMPLE_WIDTH-1:0] sample, zero padded to bytes
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // window_extreme, then running_aggregate, zero padded to bytes
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata,
    // [0] window_ready, [1] aggregate_valid
    output logic [1:0]                             m_tuser,
    output logic                                   m_tlast
);
    import swe_pkg::*;

    localparam int M_TDATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;
    localparam int KW        = $clog2(MAX_WINDOW+1);

    logic                           s_acc;
    swe_ctrl_t                      ctrl;
    logic signed [SAMPLE_WIDTH-1:0] x;

    logic                           keep_w  [0:MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] val_w   [0:MAX_WINDOW];
    logic [POS_W-1:0]               pos_w   [0:MAX_WINDOW];
    logic [MAX_WINDOW-1:0]          valid_vec;

    logic [WS_W-1:0]                ws_reg, ws_next;
    logic                           mode_reg, mode_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic signed [SAMPLE_WIDTH-1:0] agg_reg, agg_next;
    logic                           seen_reg, seen_next;

    logic                           m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] ext_out_reg, agg_out_reg;
    logic                           ready_out_reg, aggv_out_reg, last_out_reg;

    logic [KW-1:0]                  k;
    logic [POS_W-1:0]               k_ext;
    logic                           front_exp, full, shift;
    logic                           win_ready, agg_upd;
    logic signed [SAMPLE_WIDTH-1:0] ext_sel, ext_val, agg_new;
    logic                           seen_new;

    assign s_tready = ~m_valid_reg | m_tready;
    assign s_acc    = s_tvalid & s_tready;
    assign x        = s_tdata[SAMPLE_WIDTH-1:0];

    // window size clamped to 1..MAX_WINDOW
    always_comb begin
        if (ws_reg == '0) begin
            k = KW'(1);
        end else if (POS_W'(ws_reg) > POS_W'(MAX_WINDOW)) begin
            k = KW'(MAX_WINDOW);
        end else begin
            k = KW'(ws_reg);
        end
    end
    assign k_ext = POS_W'(k);

    assign front_exp = valid_vec[0] & ((pos_reg - pos_w[0]) >= k_ext);
    assign full      = keep_w[MAX_WINDOW-1];
    assign shift     = (front_exp | full) & keep_w[0];

    assign ctrl.step  = s_acc;
    assign ctrl.shift = shift;
    assign ctrl.clear = s_acc & s_tlast;
    assign ctrl.mode  = mode_reg;

    assign keep_w[MAX_WINDOW] = 1'b0;
    assign val_w[MAX_WINDOW]  = '0;
    assign pos_w[MAX_WINDOW]  = '0;

    for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
        logic left_k;
        if (j == 0) begin : g_head
            assign left_k = 1'b1;
        end else begin : g_body
            assign left_k = keep_w[j-1];
        end
        swe_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .in_sample   (x),
            .in_pos      (pos_reg),
            .left_keep   (left_k),
            .right_keep  (keep_w[j+1]),
            .right_value (val_w[j+1]),
            .right_pos   (pos_w[j+1]),
            .keep        (keep_w[j]),
            .valid       (valid_vec[j]),
            .value       (val_w[j]),
            .pos         (pos_w[j])
        );
    end

    // front of the deque after this step
    always_comb begin
        if (shift) begin
            ext_sel = keep_w[1] ? val_w[1] : x;
        end else begin
            ext_sel = keep_w[0] ? val_w[0] : x;
        end
    end

    assign win_ready = pos_reg >= (k_ext - POS_W'(1));
    assign ext_val   = win_ready ? ext_sel : '0;
    assign agg_upd   = win_ready & (~seen_reg |
                       ((mode_reg == MODE_MIN) ? (ext_sel > agg_reg) : (ext_sel < agg_reg)));
    assign agg_new   = agg_upd ? ext_sel : agg_reg;
    assign seen_new  = seen_reg | win_ready;

    always_comb begin
        ws_next      = ws_reg;
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        agg_next     = agg_reg;
        seen_next    = seen_reg;
        m_valid_next = m_valid_reg;
        if (cfg_we) begin
            case (cfg_idx)
                REG_WINDOW_SIZE: begin
                    ws_next = cfg_wdata;
                end
                REG_EXTREME_MODE: begin
                    mode_next = cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_acc) begin
            m_valid_next = 1'b1;
            if (s_tlast) begin
                pos_next  = '0;
                agg_next  = '0;
                seen_next = 1'b0;
            end else begin
                pos_next  = pos_reg + POS_W'(1);
                agg_next  = agg_new;
                seen_next = seen_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg      <= WS_RESET;
            mode_reg    <= MODE_MAX;
            pos_reg     <= '0;
            agg_reg     <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            ws_reg      <= ws_next;
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            agg_reg     <= agg_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            ext_out_reg   <= ext_val;
            agg_out_reg   <= agg_new;
            ready_out_reg <= win_ready;
            aggv_out_reg  <= seen_new;
            last_out_reg  <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({agg_out_reg, ext_out_reg});
    assign m_tuser  = {aggv_out_reg, ready_out_reg};
    assign m_tlast  = last_out_reg;

    `include "sliding_window_extremum_macros.svh"

    // deque entries always form an unbroken run from the front
    `SWE_ASSERT(a_valid_prefix, aclk, aresetn,
        ((valid_vec >> 1) & ~valid_vec) == '0, "deque valid bits not a prefix")
    // a last word leaves the block empty
    `SWE_ASSERT_NXT(a_last_clears, aclk, aresetn, s_acc && s_tlast,
        pos_reg == '0 && valid_vec == '0 && !seen_reg, "state not cleared after last word")
    // a word that is not last leaves at least its own sample in the deque
    `SWE_ASSERT_NXT(a_sample_kept, aclk, aresetn, s_acc && !s_tlast,
        valid_vec[0], "deque empty after a sample")
    // a full window always yields a valid aggregate
    `SWE_ASSERT_IMP(a_ready_agg, aclk, aresetn, m_tvalid && m_tuser[0],
        m_tuser[1], "window ready without aggregate")

endmodule
